// ===== design/csv_record_field_framer_assert.svh =====
// assertion macros for the csv framer, clocked on clk with arst_n low disabling
`ifndef CSV_RECORD_FIELD_FRAMER_ASSERT_SVH
`define CSV_RECORD_FIELD_FRAMER_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define CSVF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CSVF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CSVF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/csvf_pkg.sv =====
package csvf_pkg;

	localparam int unsigned CHUNK_W = 17;
	localparam int unsigned MAX_EVENTS = 6;
	localparam int unsigned EV_CNT_W = 3;

	localparam logic [CHUNK_W-1:0] MIN_CHUNK = 17'h00100;
	localparam logic [CHUNK_W-1:0] MAX_CHUNK = 17'h10000;

	// token kinds on the input channel
	localparam logic [1:0] TOK_DATA = 2'd0;
	localparam logic [1:0] TOK_SEP = 2'd1;
	localparam logic [1:0] TOK_EOL = 2'd2;
	localparam logic [1:0] TOK_EOI = 2'd3;

	typedef enum logic [2:0] {
		EV_FILE_START = 3'd0,
		EV_RECORD_START = 3'd1,
		EV_FIELD_START = 3'd2,
		EV_FIELD_BYTE = 3'd3,
		EV_CHUNK_END = 3'd4,
		EV_FIELD_END = 3'd5,
		EV_RECORD_END = 3'd6,
		EV_FILE_END = 3'd7
	} event_t;

endpackage

// ===== design/csv_record_field_framer.sv =====
// csv record and field framer: each token expands into zero to six events.
// each token's events are loaded into the event list (ev_s1) and moved one at a time into the
// output register, one event per cycle unless out_stall holds it; in_stall holds the next
// token until the last event of the current one moves to the output register.
// reset (arst_n low): awaiting first token, chunk count zero, chunk_size 65536, outputs empty.
`include "csv_record_field_framer_assert.svh"

module csv_record_field_framer (
	input  logic                           clk,
	input  logic                           arst_n,
	// token input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     token_kind,
	input  logic [7:0]                     in_byte,
	// event output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     event_res,
	output logic [7:0]                     out_byte,
	output logic                           last,
	// chunk size register write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [csvf_pkg::CHUNK_W-1:0]   chunk_size
);

	typedef enum logic [2:0] {
		PH_AWAIT,
		PH_FIELD_OPEN,
		PH_BYTES,
		PH_AFTER_RECORD,
		PH_DONE
	} phase_t;

	phase_t                          phase_q;
	logic [csvf_pkg::CHUNK_W-1:0]    chunk_count_q;
	logic [csvf_pkg::CHUNK_W-1:0]    chunk_size_q;

	// event list of the token in flight
	csvf_pkg::event_t                ev_s1 [csvf_pkg::MAX_EVENTS];
	logic [csvf_pkg::EV_CNT_W-1:0]   rem_s1;
	logic [7:0]                      byte_s1;

	// output register
	logic                            out_valid_q;
	csvf_pkg::event_t                event_q;
	logic [7:0]                      byte_q;
	logic                            last_q;

	logic                            advance;
	logic                            accept;

	// next-state and event list for the presented token
	phase_t                          ph_n;
	logic [csvf_pkg::CHUNK_W-1:0]    cc_n;
	csvf_pkg::event_t                evs [csvf_pkg::MAX_EVENTS];
	logic [csvf_pkg::EV_CNT_W-1:0]   n_ev;
	logic [csvf_pkg::CHUNK_W-1:0]    limit;
	logic [csvf_pkg::CHUNK_W-1:0]    cc_inc;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || !out_stall;
	assign in_stall = (rem_s1 > 3'd1) || ((rem_s1 == 3'd1) && !advance);
	assign accept = in_valid && !in_stall;

	// clamp the chunk limit into its legal range
	always_comb begin
		if (chunk_size_q < csvf_pkg::MIN_CHUNK) begin
			limit = csvf_pkg::MIN_CHUNK;
		end else if (chunk_size_q > csvf_pkg::MAX_CHUNK) begin
			limit = csvf_pkg::MAX_CHUNK;
		end else begin
			limit = chunk_size_q;
		end
	end

	// expand one token into its events, phases fall through in order
	always_comb begin
		ph_n = phase_q;
		cc_n = chunk_count_q;
		n_ev = '0;
		cc_inc = chunk_count_q + 17'd1;
		for (int i = 0; i < csvf_pkg::MAX_EVENTS; i++) begin
			evs[i] = csvf_pkg::EV_FILE_START;
		end

		if (ph_n == PH_AWAIT) begin
			evs[n_ev] = csvf_pkg::EV_FILE_START;
			n_ev = n_ev + 3'd1;
			ph_n = PH_AFTER_RECORD;
		end

		if (ph_n == PH_AFTER_RECORD) begin
			if (token_kind == csvf_pkg::TOK_EOI) begin
				evs[n_ev] = csvf_pkg::EV_FILE_END;
				n_ev = n_ev + 3'd1;
				ph_n = PH_DONE;
			end else begin
				evs[n_ev] = csvf_pkg::EV_RECORD_START;
				n_ev = n_ev + 3'd1;
				evs[n_ev] = csvf_pkg::EV_FIELD_START;
				n_ev = n_ev + 3'd1;
				ph_n = PH_FIELD_OPEN;
			end
		end

		if (ph_n == PH_FIELD_OPEN) begin
			if (token_kind == csvf_pkg::TOK_DATA || token_kind == csvf_pkg::TOK_SEP) begin
				cc_n = '0;
				cc_inc = 17'd1;
				ph_n = PH_BYTES;
			end else begin
				evs[n_ev] = csvf_pkg::EV_FIELD_END;
				n_ev = n_ev + 3'd1;
				evs[n_ev] = csvf_pkg::EV_RECORD_END;
				n_ev = n_ev + 3'd1;
				if (token_kind == csvf_pkg::TOK_EOI) begin
					evs[n_ev] = csvf_pkg::EV_FILE_END;
					n_ev = n_ev + 3'd1;
					ph_n = PH_DONE;
				end else begin
					ph_n = PH_AFTER_RECORD;
				end
			end
		end

		if (ph_n == PH_BYTES) begin
			if (token_kind == csvf_pkg::TOK_DATA) begin
				evs[n_ev] = csvf_pkg::EV_FIELD_BYTE;
				n_ev = n_ev + 3'd1;
				cc_n = cc_inc;
				if (cc_inc >= limit) begin
					evs[n_ev] = csvf_pkg::EV_CHUNK_END;
					n_ev = n_ev + 3'd1;
					cc_n = '0;
				end
			end else begin
				evs[n_ev] = csvf_pkg::EV_CHUNK_END;
				n_ev = n_ev + 3'd1;
				evs[n_ev] = csvf_pkg::EV_FIELD_END;
				n_ev = n_ev + 3'd1;
				cc_n = '0;
				if (token_kind == csvf_pkg::TOK_SEP) begin
					evs[n_ev] = csvf_pkg::EV_FIELD_START;
					n_ev = n_ev + 3'd1;
					ph_n = PH_FIELD_OPEN;
				end else if (token_kind == csvf_pkg::TOK_EOL) begin
					evs[n_ev] = csvf_pkg::EV_RECORD_END;
					n_ev = n_ev + 3'd1;
					ph_n = PH_AFTER_RECORD;
				end else begin
					evs[n_ev] = csvf_pkg::EV_RECORD_END;
					n_ev = n_ev + 3'd1;
					evs[n_ev] = csvf_pkg::EV_FILE_END;
					n_ev = n_ev + 3'd1;
					ph_n = PH_DONE;
				end
			end
		end
	end

	// framing state and chunk register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_AWAIT;
			chunk_count_q <= '0;
			chunk_size_q <= csvf_pkg::MAX_CHUNK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				chunk_size_q <= chunk_size;
			end
			if (accept) begin
				phase_q <= ph_n;
				chunk_count_q <= cc_n;
			end
		end
	end

	// event list control: drain one a cycle while the output advances, reload on a token transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s1 <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= (rem_s1 != 3'd0);
			end
			if (accept) begin
				rem_s1 <= n_ev;
			end else if (advance && rem_s1 != 3'd0) begin
				rem_s1 <= rem_s1 - 3'd1;
			end
		end
	end

	// event list and output payload
	always_ff @(posedge clk) begin
		if (advance && rem_s1 != 3'd0) begin
			event_q <= ev_s1[0];
			byte_q <= (ev_s1[0] == csvf_pkg::EV_FIELD_BYTE) ? byte_s1 : 8'd0;
			last_q <= (rem_s1 == 3'd1);
		end
		if (accept) begin
			ev_s1 <= evs;
			byte_s1 <= in_byte;
		end else if (advance && rem_s1 != 3'd0) begin
			for (int i = 0; i < csvf_pkg::MAX_EVENTS - 1; i++) begin
				ev_s1[i] <= ev_s1[i+1];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign out_byte = byte_q;
	assign last = last_q;

	// checks on the event sequencer
	`CSVF_ASSERT_ALWAYS(a_rem_bound, rem_s1 <= 3'd6, "event list count out of range")
	`CSVF_ASSERT_IMPL(a_more_pending, out_valid_q && !last_q, rem_s1 != 3'd0,
		"non-final event shown with no event pending")
	`CSVF_ASSERT_IMPL(a_file_end_done, out_valid_q && event_q == csvf_pkg::EV_FILE_END,
		phase_q == PH_DONE, "file end shown while framer not done")
	`CSVF_ASSERT_NEXT(a_done_sticks, phase_q == PH_DONE, phase_q == PH_DONE,
		"framer left done phase")

endmodule

// ===== bench/csv_record_field_framer_tb.sv =====
module csv_record_field_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 160;
	localparam int HOLD_AFTER_TOKENS = 40;

	typedef logic [csvf_pkg::CHUNK_W-1:0] chunk_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} token_t;

	typedef struct packed {
		csvf_pkg::event_t ev;
		logic [7:0]       data;
		logic             last;
	} event_rec_t;

	typedef enum logic [2:0] {
		FR_AWAIT        = 3'd0,
		FR_FIELD_OPEN   = 3'd1,
		FR_BYTES        = 3'd2,
		FR_AFTER_RECORD = 3'd3,
		FR_DONE         = 3'd4
	} framer_phase_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY
	} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        token_kind = csvf_pkg::TOK_DATA;
	logic [7:0]        in_byte = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        event_res;
	logic [7:0]        out_byte;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	chunk_t            cfg_chunk_size = '0;

	// tokens waiting to be driven and events waiting to come out
	token_t     token_queue[$];
	event_rec_t expected_events[$];
	event_rec_t staged[$];

	// predicted framer state
	framer_phase_t fr_phase = FR_AWAIT;
	chunk_t        bytes_in_chunk = '0;
	chunk_t        size_reg = csvf_pkg::MAX_CHUNK;

	int tokens_pushed = 0;
	int tokens_taken = 0;
	int fault_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int idle_cycles = 0;
	token_t next_tok;
	event_rec_t want;

	csv_record_field_framer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.token_kind (token_kind),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.out_byte   (out_byte),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.chunk_size (cfg_chunk_size)
	);

	always #5 clk = ~clk;

	function automatic void stage(input csvf_pkg::event_t ev, input logic [7:0] data);
		event_rec_t rec;
		rec.ev = ev;
		rec.data = (ev == csvf_pkg::EV_FIELD_BYTE) ? data : 8'h00;
		rec.last = 1'b0;
		staged.push_back(rec);
	endfunction

	// expand one accepted token into the events the framer should emit
	function automatic void expand_token(input logic [1:0] kind, input logic [7:0] data);
		chunk_t lim;
		lim = (size_reg < csvf_pkg::MIN_CHUNK) ? csvf_pkg::MIN_CHUNK :
			(size_reg > csvf_pkg::MAX_CHUNK) ? csvf_pkg::MAX_CHUNK : size_reg;
		staged.delete();
		if (fr_phase == FR_AWAIT) begin
			stage(csvf_pkg::EV_FILE_START, 8'h00);
			fr_phase = FR_AFTER_RECORD;
		end
		// a new record opens only when something other than end of input follows
		if (fr_phase == FR_AFTER_RECORD) begin
			if (kind == csvf_pkg::TOK_EOI) begin
				stage(csvf_pkg::EV_FILE_END, 8'h00);
				fr_phase = FR_DONE;
			end else begin
				stage(csvf_pkg::EV_RECORD_START, 8'h00);
				stage(csvf_pkg::EV_FIELD_START, 8'h00);
				fr_phase = FR_FIELD_OPEN;
			end
		end
		// empty field closed by end of line or input yields no chunk
		if (fr_phase == FR_FIELD_OPEN) begin
			if (kind == csvf_pkg::TOK_DATA || kind == csvf_pkg::TOK_SEP) begin
				bytes_in_chunk = '0;
				fr_phase = FR_BYTES;
			end else begin
				stage(csvf_pkg::EV_FIELD_END, 8'h00);
				stage(csvf_pkg::EV_RECORD_END, 8'h00);
				if (kind == csvf_pkg::TOK_EOI) begin
					stage(csvf_pkg::EV_FILE_END, 8'h00);
					fr_phase = FR_DONE;
				end else begin
					fr_phase = FR_AFTER_RECORD;
				end
			end
		end
		if (fr_phase == FR_BYTES) begin
			if (kind == csvf_pkg::TOK_DATA) begin
				stage(csvf_pkg::EV_FIELD_BYTE, data);
				bytes_in_chunk = bytes_in_chunk + 1'b1;
				if (bytes_in_chunk >= lim) begin
					stage(csvf_pkg::EV_CHUNK_END, 8'h00);
					bytes_in_chunk = '0;
				end
			end else begin
				stage(csvf_pkg::EV_CHUNK_END, 8'h00);
				stage(csvf_pkg::EV_FIELD_END, 8'h00);
				bytes_in_chunk = '0;
				if (kind == csvf_pkg::TOK_SEP) begin
					stage(csvf_pkg::EV_FIELD_START, 8'h00);
					fr_phase = FR_FIELD_OPEN;
				end else if (kind == csvf_pkg::TOK_EOL) begin
					stage(csvf_pkg::EV_RECORD_END, 8'h00);
					fr_phase = FR_AFTER_RECORD;
				end else begin
					stage(csvf_pkg::EV_RECORD_END, 8'h00);
					stage(csvf_pkg::EV_FILE_END, 8'h00);
					fr_phase = FR_DONE;
				end
			end
		end
		if (staged.size() > 0)
			staged[staged.size()-1].last = 1'b1;
		foreach (staged[i])
			expected_events.push_back(staged[i]);
	endfunction

	// token sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expand_token(token_kind, in_byte);
				tokens_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (token_queue.size() > 0) begin
					next_tok = token_queue.pop_front();
					token_kind <= next_tok.kind;
					in_byte <= next_tok.data;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// event receiver stall: one long hold-off, otherwise random modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (!hold_done && tokens_taken >= HOLD_AFTER_TOKENS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 80);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// compare each event transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				fault_count++;
				$display("%0t: unexpected event ev=%0d byte=%h last=%b",
					$time, event_res, out_byte, last);
			end else begin
				want = expected_events.pop_front();
				if (event_res !== want.ev || out_byte !== want.data || last !== want.last) begin
					fault_count++;
					$display("%0t: event differs, expected ev=%0d byte=%h last=%b,",
						$time, want.ev, want.data, want.last,
						" got ev=%0d byte=%h last=%b", event_res, out_byte, last);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("csv_record_field_framer: mismatch");
				$finish;
			end else begin
				idle_cycles++;
			end
		end
	end

	task automatic push_token(input logic [1:0] kind, input logic [7:0] data);
		token_t tok;
		tok.kind = kind;
		tok.data = data;
		token_queue.push_back(tok);
		tokens_pushed++;
	endtask

	task automatic push_field_bytes(input int count);
		for (int i = 0; i < count; i++)
			push_token(csvf_pkg::TOK_DATA, 8'($urandom()));
	endtask

	// records of short random fields
	task automatic push_random_records(input int budget);
		int made;
		int len;
		int pick;
		made = 0;
		while (made < budget) begin
			len = $urandom_range(0, 6);
			push_field_bytes(len);
			pick = $urandom_range(0, 99);
			push_token((pick < 60) ? csvf_pkg::TOK_SEP : csvf_pkg::TOK_EOL, 8'($urandom()));
			made += len + 1;
		end
	endtask

	// wait until every token is taken and every event has come out
	task automatic settle();
		do
			@(posedge clk);
		while (tokens_taken != tokens_pushed || expected_events.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_chunk_size(input chunk_t value);
		@(posedge clk);
		cfg_chunk_size <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = value;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// opening record: byte extremes, empty fields, empty record
		push_token(csvf_pkg::TOK_DATA, 8'h00);
		push_token(csvf_pkg::TOK_DATA, 8'hFF);
		push_token(csvf_pkg::TOK_DATA, 8'h55);
		push_token(csvf_pkg::TOK_DATA, 8'hAA);
		push_token(csvf_pkg::TOK_SEP, 8'h00);
		push_token(csvf_pkg::TOK_SEP, 8'hFF);
		push_token(csvf_pkg::TOK_EOL, 8'h00);
		push_token(csvf_pkg::TOK_EOL, 8'hFF);
		push_token(csvf_pkg::TOK_DATA, 8'h80);
		push_token(csvf_pkg::TOK_EOL, 8'h7E);
		push_token(csvf_pkg::TOK_SEP, 8'h01);
		push_token(csvf_pkg::TOK_DATA, 8'h01);
		push_token(csvf_pkg::TOK_EOL, 8'h00);
		settle();

		// zero is raised to the minimum chunk
		write_chunk_size('0);
		push_random_records(20);
		settle();

		// oversized value is lowered; then shrink the limit inside a long field
		write_chunk_size('1);
		push_token(csvf_pkg::TOK_SEP, 8'($urandom()));
		push_field_bytes(262);
		settle();
		write_chunk_size(csvf_pkg::MIN_CHUNK);
		push_random_records(16);
		settle();

		write_chunk_size(chunk_t'($urandom_range(257, 320)));
		push_random_records(16);
		settle();

		// trailing end of line, end of input, then ignored tokens
		write_chunk_size(csvf_pkg::MAX_CHUNK);
		push_token(csvf_pkg::TOK_DATA, 8'($urandom()));
		push_token(csvf_pkg::TOK_EOL, 8'h00);
		push_token(csvf_pkg::TOK_EOI, 8'hFF);
		push_token(csvf_pkg::TOK_DATA, 8'h5A);
		push_token(csvf_pkg::TOK_SEP, 8'h00);
		push_token(csvf_pkg::TOK_EOL, 8'h00);
		push_token(csvf_pkg::TOK_EOI, 8'h00);
		settle();
		repeat (12) @(posedge clk);

		if (fault_count == 0 && expected_events.size() == 0)
			$display("csv_record_field_framer: match");
		else
			$display("csv_record_field_framer: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/csvf_pkg.sv
design/csv_record_field_framer.sv
bench/csv_record_field_framer_tb.sv
